// ----- src/dtmfg_pkg.sv -----
// Shared types, constants and the coefficient table of the DTMF Goertzel detector.
package dtmfg_pkg;

    localparam int TONES  = 8;
    localparam int TONE_W = 3;
    localparam int CNT_W  = 15;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SAT_W  = 31;
    localparam int PWR_W  = 63;
    localparam int COEF_W = 21;

    localparam logic [CNT_W-1:0] BLK_RESET = 15'd256;

    // 2*cos(2*pi*f/8000) with 20 fraction bits, rows then columns
    localparam logic [COEF_W-1:0] COEF_Q20 [TONES] = '{
        21'd1790693, 21'd1725202, 21'd1644888, 21'd1550010,
        21'd1220652, 21'd1044770, 21'd837412,  21'd596150
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RRD,
        ST_RLD,
        ST_RLO,
        ST_RHI,
        ST_RWB,
        ST_CNT,
        ST_PRD,
        ST_PSAT,
        ST_PCA,
        ST_PAA,
        ST_PBB,
        ST_PTB,
        ST_PSUM,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MUL_C_LO,
        MUL_C_HI,
        MUL_C_A,
        MUL_A_A,
        MUL_B_B,
        MUL_T_B
    } t_mul_sel;

    typedef struct packed {
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ld_res;
        logic     ld_lo;
        logic     ld_sat;
        logic     ld_t;
        logic     ld_acc;
        logic     add_acc;
    } t_dp_ctrl;

    // coefficient rounded half-up to frac fraction bits
    function automatic logic [COEF_W-1:0] coef(input logic [TONE_W-1:0] idx, input int frac);
        logic [COEF_W+1:0] v;
        v = ({1'b0, COEF_Q20[idx], 1'b0}) + ((COEF_W+2)'(1) << (20 - frac));
        return COEF_W'(v >> (21 - frac));
    endfunction

endpackage

// ----- src/dtmfg_ram.sv -----
// Resonator state memory: eight entries of both delays, registered read.
module dtmfg_ram #(
    parameter int WIDTH = 96
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [dtmfg_pkg::TONE_W-1:0]    i_waddr,
    input  logic [WIDTH-1:0]                i_wdata,
    input  logic [dtmfg_pkg::TONE_W-1:0]    i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [dtmfg_pkg::TONES];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/dtmfg_dp.sv -----
// Shared multiplier datapath: resonator update and tone power.
module dtmfg_dp #(
    parameter int ACC_BITS        = 48,
    parameter int COEFF_FRAC_BITS = 14
) (
    input  logic                            i_clk,
    input  dtmfg_pkg::t_dp_ctrl             i_ctrl,
    input  logic [dtmfg_pkg::TONE_W-1:0]    i_tone,
    input  logic                            i_entry_vld,
    input  logic [2*ACC_BITS-1:0]           i_rdata,
    input  logic signed [ACC_BITS-1:0]      i_x,
    output logic [2*ACC_BITS-1:0]           o_wdata,
    output logic [dtmfg_pkg::PWR_W-1:0]     o_pwr
);

    localparam int F = COEFF_FRAC_BITS;

    logic [dtmfg_pkg::COEF_W-1:0]           c;
    logic signed [ACC_BITS-1:0]             s1_in;
    logic signed [ACC_BITS-1:0]             s2_in;
    logic signed [ACC_BITS-1:0]             r_s1;
    logic signed [ACC_BITS-1:0]             r_s2;
    logic [63:0]                            s1_64;
    logic signed [dtmfg_pkg::SAT_W-1:0]     r_a;
    logic signed [dtmfg_pkg::SAT_W-1:0]     r_b;
    logic signed [31:0]                     r_t;
    logic [63:0]                            r_plo;
    logic signed [63:0]                     r_acc;
    logic signed [dtmfg_pkg::MUL_W-1:0]     op_a;
    logic signed [dtmfg_pkg::MUL_W-1:0]     op_b;
    logic signed [dtmfg_pkg::PROD_W-1:0]    r_prod;
    logic [63:0]                            up;
    logic [63:0]                            dn;
    logic [63:0]                            s64;
    logic signed [63:0]                     diff;

    function automatic logic signed [dtmfg_pkg::SAT_W-1:0] sat(input logic signed [63:0] v);
        if (v > 64'sd1073741823) begin
            return 31'sh3FFFFFFF;
        end else if (v < -64'sd1073741824) begin
            return 31'sh40000000;
        end
        return v[dtmfg_pkg::SAT_W-1:0];
    endfunction

    assign c     = dtmfg_pkg::coef(i_tone, F);
    // entries not written since the last block end read as zero
    assign s1_in = i_entry_vld ? i_rdata[ACC_BITS-1:0] : '0;
    assign s2_in = i_entry_vld ? i_rdata[2*ACC_BITS-1:ACC_BITS] : '0;
    assign s1_64 = 64'(r_s1);

    always_comb begin
        op_a = $signed(dtmfg_pkg::MUL_W'(c));
        op_b = '0;
        case (i_ctrl.mul_sel)
            dtmfg_pkg::MUL_C_LO: op_b = $signed({1'b0, s1_64[31:0]});
            dtmfg_pkg::MUL_C_HI: op_b = dtmfg_pkg::MUL_W'($signed(s1_64[63:32]));
            dtmfg_pkg::MUL_C_A:  op_b = dtmfg_pkg::MUL_W'(r_a);
            dtmfg_pkg::MUL_A_A: begin
                op_a = dtmfg_pkg::MUL_W'(r_a);
                op_b = dtmfg_pkg::MUL_W'(r_a);
            end
            dtmfg_pkg::MUL_B_B: begin
                op_a = dtmfg_pkg::MUL_W'(r_b);
                op_b = dtmfg_pkg::MUL_W'(r_b);
            end
            dtmfg_pkg::MUL_T_B: begin
                op_a = dtmfg_pkg::MUL_W'(r_t);
                op_b = dtmfg_pkg::MUL_W'(r_b);
            end
            default: op_b = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= op_a * op_b;
        end
        if (i_ctrl.ld_res) begin
            r_s1 <= s1_in;
            r_s2 <= s2_in;
        end
        if (i_ctrl.ld_lo) begin
            r_plo <= r_prod[63:0];
        end
        if (i_ctrl.ld_sat) begin
            r_a <= sat(64'(s1_in));
            r_b <= sat(64'(s2_in));
        end
        if (i_ctrl.ld_t) begin
            r_t <= 32'(r_prod >>> F);
        end
        if (i_ctrl.ld_acc) begin
            r_acc <= $signed(r_prod[63:0]);
        end else if (i_ctrl.add_acc) begin
            r_acc <= r_acc + $signed(r_prod[63:0]);
        end
    end

    // floor(c*s1/2^F) from the two partial products, modulo 2^64
    assign up  = r_prod[63:0] << (32 - F);
    assign dn  = r_plo >> F;
    assign s64 = 64'(i_x) + up + dn - 64'(r_s2);

    assign o_wdata = {r_s1, s64[ACC_BITS-1:0]};

    assign diff  = r_acc - $signed(r_prod[63:0]);
    assign o_pwr = diff[63] ? '0 : diff[dtmfg_pkg::PWR_W-1:0];

endmodule

// ----- src/dtmfg_peak.sv -----
// Running search for the two strongest tones, ties to the lower index.
module dtmfg_peak (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic                            i_first,
    input  logic [dtmfg_pkg::TONE_W-1:0]    i_idx,
    input  logic [dtmfg_pkg::PWR_W-1:0]     i_pwr,
    output logic [dtmfg_pkg::TONE_W-1:0]    o_idx1,
    output logic [dtmfg_pkg::TONE_W-1:0]    o_idx2
);

    logic [dtmfg_pkg::PWR_W-1:0]  r_v1;
    logic [dtmfg_pkg::PWR_W-1:0]  r_v2;
    logic [dtmfg_pkg::TONE_W-1:0] r_i1;
    logic [dtmfg_pkg::TONE_W-1:0] r_i2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_first) begin
                // runner-up defaults to tone one at zero power
                r_v1 <= i_pwr;
                r_i1 <= i_idx;
                r_v2 <= '0;
                r_i2 <= dtmfg_pkg::TONE_W'(1);
            end else if (i_pwr > r_v1) begin
                r_v2 <= r_v1;
                r_i2 <= r_i1;
                r_v1 <= i_pwr;
                r_i1 <= i_idx;
            end else if (i_pwr > r_v2) begin
                r_v2 <= i_pwr;
                r_i2 <= i_idx;
            end
        end
    end

    assign o_idx1 = r_i1;
    assign o_idx2 = r_i2;

endmodule

// ----- src/dtmf_goertzel_detector.sv -----
// Top level of the eight-tone Goertzel DTMF detector.
//
//  channel   ports                                  handshake
//  sample    i_sample                               start & !busy
//  result    o_digit_code, o_detect_error           o_valid, one cycle
//  config    i_cfg_wdata (block_length)             i_cfg_we
//
// Each request steps every tone through the shared multiplier, with the
// state memory read, modified and written back, plus accept and count cycles.
// The last sample of a block adds eight power sums of seven steps each.
// Reset clears the state through per-tone valid bits; block length 256.
// The result strobe cannot be stalled.
module dtmf_goertzel_detector #(
    parameter int SAMPLE_BITS     = 16,
    parameter int COEFF_FRAC_BITS = 14,
    parameter int ACC_BITS        = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic                            i_cfg_we,
    input  logic [dtmfg_pkg::CNT_W-1:0]     i_cfg_wdata,
    output logic                            o_valid,
    output logic [3:0]                      o_digit_code,
    output logic                            o_detect_error
);

    dtmfg_pkg::t_state               r_state;
    dtmfg_pkg::t_state               n_state;
    dtmfg_pkg::t_dp_ctrl             ctrl;
    logic [dtmfg_pkg::TONE_W-1:0]    r_tone;
    logic [dtmfg_pkg::TONES-1:0]     r_vld;
    logic [dtmfg_pkg::CNT_W-1:0]     r_count;
    logic [dtmfg_pkg::CNT_W-1:0]     n_count;
    logic [dtmfg_pkg::CNT_W-1:0]     r_blk_len;
    logic signed [ACC_BITS-1:0]      r_x;
    logic [2*ACC_BITS-1:0]           rdata;
    logic [2*ACC_BITS-1:0]           wdata;
    logic [dtmfg_pkg::PWR_W-1:0]     pwr;
    logic [dtmfg_pkg::TONE_W-1:0]    idx1;
    logic [dtmfg_pkg::TONE_W-1:0]    idx2;
    logic                            last_tone;
    logic                            accept;

    assign last_tone = (r_tone == dtmfg_pkg::TONE_W'(dtmfg_pkg::TONES - 1));
    assign accept    = start && !busy;
    assign n_count   = r_count + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dtmfg_pkg::ST_IDLE: if (start) n_state = dtmfg_pkg::ST_RRD;
            dtmfg_pkg::ST_RRD:  n_state = dtmfg_pkg::ST_RLD;
            dtmfg_pkg::ST_RLD:  n_state = dtmfg_pkg::ST_RLO;
            dtmfg_pkg::ST_RLO:  n_state = dtmfg_pkg::ST_RHI;
            dtmfg_pkg::ST_RHI:  n_state = dtmfg_pkg::ST_RWB;
            dtmfg_pkg::ST_RWB:
                n_state = last_tone ? dtmfg_pkg::ST_CNT : dtmfg_pkg::ST_RRD;
            dtmfg_pkg::ST_CNT:
                n_state = (n_count >= r_blk_len) ? dtmfg_pkg::ST_PRD : dtmfg_pkg::ST_IDLE;
            dtmfg_pkg::ST_PRD:  n_state = dtmfg_pkg::ST_PSAT;
            dtmfg_pkg::ST_PSAT: n_state = dtmfg_pkg::ST_PCA;
            dtmfg_pkg::ST_PCA:  n_state = dtmfg_pkg::ST_PAA;
            dtmfg_pkg::ST_PAA:  n_state = dtmfg_pkg::ST_PBB;
            dtmfg_pkg::ST_PBB:  n_state = dtmfg_pkg::ST_PTB;
            dtmfg_pkg::ST_PTB:  n_state = dtmfg_pkg::ST_PSUM;
            dtmfg_pkg::ST_PSUM:
                n_state = last_tone ? dtmfg_pkg::ST_OUT : dtmfg_pkg::ST_PRD;
            dtmfg_pkg::ST_OUT:  n_state = dtmfg_pkg::ST_IDLE;
            default:            n_state = dtmfg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl         = '0;
        ctrl.mul_sel = dtmfg_pkg::MUL_C_LO;
        case (r_state)
            dtmfg_pkg::ST_RLD:  ctrl.ld_res = 1'b1;
            dtmfg_pkg::ST_RLO:  ctrl.mul_en = 1'b1;
            dtmfg_pkg::ST_RHI: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = dtmfg_pkg::MUL_C_HI;
                ctrl.ld_lo   = 1'b1;
            end
            dtmfg_pkg::ST_PSAT: ctrl.ld_sat = 1'b1;
            dtmfg_pkg::ST_PCA: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = dtmfg_pkg::MUL_C_A;
            end
            dtmfg_pkg::ST_PAA: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = dtmfg_pkg::MUL_A_A;
                ctrl.ld_t    = 1'b1;
            end
            dtmfg_pkg::ST_PBB: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = dtmfg_pkg::MUL_B_B;
                ctrl.ld_acc  = 1'b1;
            end
            dtmfg_pkg::ST_PTB: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = dtmfg_pkg::MUL_T_B;
                ctrl.add_acc = 1'b1;
            end
            default: ctrl.mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dtmfg_pkg::ST_IDLE;
            r_tone    <= '0;
            r_vld     <= '0;
            r_count   <= '0;
            r_blk_len <= dtmfg_pkg::BLK_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_blk_len <= i_cfg_wdata;
            end
            if (r_state == dtmfg_pkg::ST_RWB || r_state == dtmfg_pkg::ST_PSUM) begin
                r_tone <= r_tone + 1'b1;
            end
            if (r_state == dtmfg_pkg::ST_RWB) begin
                r_vld[r_tone] <= 1'b1;
            end
            if (r_state == dtmfg_pkg::ST_CNT) begin
                r_count <= n_count;
            end
            if (r_state == dtmfg_pkg::ST_OUT) begin
                r_vld   <= '0;
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= ACC_BITS'(i_sample);
        end
    end

    dtmfg_ram #(
        .WIDTH (2 * ACC_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == dtmfg_pkg::ST_RWB),
        .i_waddr (r_tone),
        .i_wdata (wdata),
        .i_raddr (r_tone),
        .o_rdata (rdata)
    );

    dtmfg_dp #(
        .ACC_BITS        (ACC_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_tone      (r_tone),
        .i_entry_vld (r_vld[r_tone]),
        .i_rdata     (rdata),
        .i_x         (r_x),
        .o_wdata     (wdata),
        .o_pwr       (pwr)
    );

    dtmfg_peak u_peak (
        .i_clk   (i_clk),
        .i_en    (r_state == dtmfg_pkg::ST_PSUM),
        .i_first (r_tone == '0),
        .i_idx   (r_tone),
        .i_pwr   (pwr),
        .o_idx1  (idx1),
        .o_idx2  (idx2)
    );

    // a valid pair is one row tone (index bit 2 clear) and one column tone
    always_comb begin
        busy           = (r_state != dtmfg_pkg::ST_IDLE);
        o_valid        = (r_state == dtmfg_pkg::ST_OUT);
        o_detect_error = (idx1[2] == idx2[2]);
        if (o_detect_error) begin
            o_digit_code = '0;
        end else if (idx1[2]) begin
            o_digit_code = {idx2[1:0], idx1[1:0]};
        end else begin
            o_digit_code = {idx1[1:0], idx2[1:0]};
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request accepted but detector not busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (r_vld == '0 && r_count == '0 && !busy))
        else $error("resonator state not cleared after a result");

    a_writeback_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtmfg_pkg::ST_RWB) |=> r_vld[$past(r_tone)])
        else $error("written entry not marked valid");

endmodule
